// ===== rtl/sorted_priority_queue_assert.svh =====
// Assertion macros used by the checker file of the sorted priority queue.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: widths, codes and cell types.
// No dependencies.
package spq_pkg;

  localparam int VALUE_W       = 32;
  localparam int PRIO_W        = 8;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 4;
  localparam int DEF_DEPTH     = 8;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_op_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, takes the new word, its left
// neighbour or its right neighbour. Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic     clk,
  input  cell_op_t op,
  input  entry_t   new_ent,
  input  logic     occ,
  input  logic     left_ins,
  input  entry_t   left_ent,
  input  entry_t   right_ent,
  output logic     ins,
  output entry_t   ent
);

  entry_t ent_r, ent_nxt;

  // new word belongs at or before this slot
  assign ins = !occ || (ent_r.prio > new_ent.prio);

  always_comb begin
    ent_nxt = ent_r;
    if (op.enq) begin
      if (left_ins) begin
        ent_nxt = left_ent;
      end else if (ins) begin
        ent_nxt = new_ent;
      end
    end else if (op.deq) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue: top level, chain of spq_cell slots plus count.
// Depends on spq_pkg and spq_cell.
// Result is strobed in the cycle after the command is taken.
// Throughput: one command per cycle; busy is never raised, the whole chain
// shifts or inserts together on each taken command.
// Reset (rst_n low, synchronous) empties the queue and clears out_valid.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic signed [VALUE_W-1:0] in_data_value,
  input  logic        [PRIO_W-1:0]  in_priority_req,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [STATUS_W-1:0]       out_status,
  output logic [OCC_W-1:0]          out_occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        out_valid_r;
  logic signed [VALUE_W-1:0]   out_value_r;
  logic [STATUS_W-1:0]         out_status_r;
  logic [OCC_W-1:0]            out_occ_r;

  logic                        acc, full, empty, enq_ok, deq_ok;
  status_t                     status;
  cell_op_t                    op;
  entry_t                      new_ent;
  logic   [QUEUE_DEPTH:0]      ins_w;
  entry_t                      ent_w [QUEUE_DEPTH];

  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (cnt_r == '0);
  assign enq_ok = acc && (in_command == CMD_ENQ) && !full;
  assign deq_ok = acc && (in_command == CMD_DEQ) && !empty;

  assign op.enq        = enq_ok;
  assign op.deq        = deq_ok;
  assign new_ent.value = in_data_value;
  assign new_ent.prio  = in_priority_req;
  assign ins_w[0]      = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   occ;

    assign occ = (cnt_r > CNT_W'(i));
    if (i == 0) begin : g_first
      assign left_ent = new_ent;
    end else begin : g_mid
      assign left_ent = ent_w[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = ent_w[i];
    end else begin : g_inner
      assign right_ent = ent_w[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .op        (op),
      .new_ent   (new_ent),
      .occ       (occ),
      .left_ins  (ins_w[i]),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ins       (ins_w[i+1]),
      .ent       (ent_w[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (enq_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (deq_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    status = ST_OK;
    if (acc && (in_command == CMD_ENQ) && full) begin
      status = ST_OVERFLOW;
    end else if (acc && (in_command == CMD_DEQ) && empty) begin
      status = ST_UNDERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= deq_ok ? ent_w[0].value : '0;
    out_status_r <= status;
    out_occ_r    <= OCC_W'(cnt_nxt);
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_assert.svh.
`include "sorted_priority_queue_assert.svh"

module spq_checker import spq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_DEPTH
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic signed [VALUE_W-1:0] out_value,
  input logic [STATUS_W-1:0]       out_status,
  input logic [OCC_W-1:0]          out_occupancy
);

  `SPQ_ASSERT_NEXT(a_word_follows, start && !busy, out_valid, "missing result word")
  `SPQ_ASSERT_NOW(a_no_spurious, out_valid, $past(start && !busy),
    "unrequested result word")
  `SPQ_ASSERT_NOW(a_err_zero, out_valid && out_status != ST_OK, out_value == '0,
    "error word carries data")
  `SPQ_ASSERT_NOW(a_ovf_full, out_valid && out_status == ST_OVERFLOW,
    out_occupancy == OCC_W'(QUEUE_DEPTH), "overflow while not full")
  `SPQ_ASSERT_NOW(a_udf_empty, out_valid && out_status == ST_UNDERFLOW,
    out_occupancy == '0, "underflow while not empty")

endmodule

bind sorted_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for sorted_priority_queue: directed corner cases, then random bursts.
// A scoreboard class predicts each result word; depends on spq_pkg and the RTL alone.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int DEPTH      = DEF_DEPTH;
  localparam int RAND_WORDS = 1730;
  localparam int STALL_MAX  = 2000;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic        [OCC_W-1:0]   occ;
  } outcome_t;

  class queue_scoreboard;
    entry_t      slots[DEPTH];
    int unsigned held;
    outcome_t    pending[$];
    int          mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function void note_command(cmd_t cmd, logic signed [VALUE_W-1:0] value,
                               logic [PRIO_W-1:0] prio);
      outcome_t o;
      int       pos;
      int       k;
      o.value  = '0;
      o.status = ST_OK;
      if (cmd == CMD_ENQ) begin
        if (held >= DEPTH) begin
          o.status = ST_OVERFLOW;
        end else begin
          pos = held;
          while (pos > 0 && slots[pos-1].prio > prio) begin
            slots[pos] = slots[pos-1];
            pos--;
          end
          slots[pos].value = value;
          slots[pos].prio  = prio;
          held++;
        end
      end else begin
        if (held == 0) begin
          o.status = ST_UNDERFLOW;
        end else begin
          o.value = slots[0].value;
          for (k = 1; k < held; k++) slots[k-1] = slots[k];
          held--;
        end
      end
      o.occ = OCC_W'(held);
      pending.push_back(o);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] value,
                               logic [STATUS_W-1:0] status, logic [OCC_W-1:0] occ);
      outcome_t o;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected word: value %0d status %0d occupancy %0d", value, status, occ);
        return;
      end
      o = pending.pop_front();
      if (o.value !== value || o.status !== status || o.occ !== occ) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: value exp %0d act %0d, status exp %0d act %0d, occ exp %0d act %0d",
                   o.value, value, o.status, status, o.occ, occ);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_command;
  logic signed [VALUE_W-1:0] in_data_value;
  logic        [PRIO_W-1:0]  in_priority_req;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic [STATUS_W-1:0]       out_status;
  logic [OCC_W-1:0]          out_occupancy;

  queue_scoreboard board;
  int              send_idle_pct;
  int              stall_cycles;

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk, .rst_n, .start, .busy,
    .in_command, .in_data_value, .in_priority_req,
    .out_valid, .out_value, .out_status, .out_occupancy
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_value, out_status, out_occupancy);
    if (rst_n && start && !busy)
      board.note_command(cmd_t'(in_command), in_data_value, in_priority_req);
    if ((rst_n && start && !busy) || (rst_n && out_valid)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(cmd_t cmd, logic signed [VALUE_W-1:0] value,
                           logic [PRIO_W-1:0] prio);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      start           = 1'b0;
      in_command      = 1'($urandom_range(1, 0));
      in_data_value   = $urandom;
      in_priority_req = PRIO_W'($urandom);
      @(negedge clk);
    end
    start           = 1'b1;
    in_command      = cmd;
    in_data_value   = value;
    in_priority_req = prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9, 0))
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int               words;
    int               run_len;
    int               enq_pct;
    bit               narrow;
    logic [PRIO_W-1:0] p;
    board           = new();
    stall_cycles    = 0;
    send_idle_pct   = 8;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_command      = CMD_ENQ;
    in_data_value   = '0;
    in_priority_req = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_word(CMD_DEQ, $urandom, PRIO_W'($urandom));
    send_word(CMD_ENQ, 32'sh7fff_ffff, 8'hff);
    send_word(CMD_ENQ, 32'sh8000_0000, 8'h00);
    send_word(CMD_ENQ, 32'sd0, 8'h80);
    send_word(CMD_ENQ, -32'sd1, 8'h80);
    send_word(CMD_ENQ, 32'sd5, 8'h00);
    send_word(CMD_ENQ, 32'sh5555_5555, 8'haa);
    send_word(CMD_ENQ, 32'shaaaa_aaaa, 8'h55);
    send_word(CMD_ENQ, 32'sd7, 8'hff);
    send_word(CMD_ENQ, 32'sd9, 8'h00);
    repeat (DEPTH) send_word(CMD_DEQ, $urandom, PRIO_W'($urandom));
    send_word(CMD_DEQ, 32'sh7fff_ffff, 8'hff);
    send_word(CMD_ENQ, 32'sh1234_5678, 8'hff);

    words = 0;
    while (words < RAND_WORDS) begin
      if (words < RAND_WORDS / 3) send_idle_pct = 8;
      else if (words < 2 * RAND_WORDS / 3) send_idle_pct = 84;
      else send_idle_pct = 0;
      run_len = $urandom_range(40, 4);
      case ($urandom_range(3, 0))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      narrow = 1'($urandom_range(1, 0));
      repeat (run_len) begin
        p = narrow ? PRIO_W'($urandom_range(3, 0)) : PRIO_W'($urandom);
        if ($urandom_range(99, 0) < enq_pct) send_word(CMD_ENQ, pick_value(), p);
        else send_word(CMD_DEQ, $urandom, PRIO_W'($urandom));
        words++;
      end
    end

    start = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ===== sorted_priority_queue.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
bench/tb.sv
